/* design/qrenc_pkg.sv */
// Package for the QR data segment bit encoder.
// Holds the mode codes, group widths, kanji ranges and the alphanumeric lookup.
// No dependencies.
`default_nettype none

package qrenc_pkg;

    // Mode register codes.
    localparam logic [1:0] MODE_NUMERIC = 2'd0;
    localparam logic [1:0] MODE_ALNUM   = 2'd1;
    localparam logic [1:0] MODE_BYTE    = 2'd2;
    localparam logic [1:0] MODE_KANJI   = 2'd3;

    // Register indexes.
    localparam logic REG_MODE = 1'b0;

    // Group bit counts.
    localparam logic [3:0] BC_NONE      = 4'd0;
    localparam logic [3:0] BC_NUM_ONE   = 4'd4;
    localparam logic [3:0] BC_ALNUM_ONE = 4'd6;
    localparam logic [3:0] BC_NUM_TWO   = 4'd7;
    localparam logic [3:0] BC_BYTE      = 4'd8;
    localparam logic [3:0] BC_NUM_THREE = 4'd10;
    localparam logic [3:0] BC_ALNUM_TWO = 4'd11;
    localparam logic [3:0] BC_KANJI     = 4'd13;

    // Shift-JIS kanji ranges and the offsets subtracted from them.
    localparam logic [15:0] KANJI_LO_FIRST  = 16'd33088;
    localparam logic [15:0] KANJI_HI_FIRST  = 16'd40956;
    localparam logic [15:0] KANJI_LO_SECOND = 16'd57408;
    localparam logic [15:0] KANJI_HI_SECOND = 16'd60351;
    localparam logic [15:0] KANJI_OFS_SECOND = 16'd49472;

    // Character codes used by the numeric and alphanumeric tables.
    localparam logic [15:0] CHAR_ZERO  = 16'd48;
    localparam logic [15:0] CHAR_NINE  = 16'd57;
    localparam logic [15:0] CHAR_UPA   = 16'd65;
    localparam logic [15:0] CHAR_UPZ   = 16'd90;
    localparam logic [15:0] LETTER_OFS = 16'd55;

    // Alphanumeric lookup result.
    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } t_alnum;

    // Map a character to its alphanumeric value 0..44; unknown ones give 1 and bad.
    function automatic t_alnum alnum_lookup(input logic [15:0] c);
        t_alnum     res;
        logic [15:0] diff;
        res  = '{bad: 1'b0, value: 6'd1};
        diff = 16'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff      = c - CHAR_ZERO;
            res.value = diff[5:0];
        end else if (c >= CHAR_UPA && c <= CHAR_UPZ) begin
            diff      = c - LETTER_OFS;
            res.value = diff[5:0];
        end else begin
            case (c)
                16'd32: res.value = 6'd36;
                16'd36: res.value = 6'd37;
                16'd37: res.value = 6'd38;
                16'd42: res.value = 6'd39;
                16'd43: res.value = 6'd40;
                16'd45: res.value = 6'd41;
                16'd46: res.value = 6'd42;
                16'd47: res.value = 6'd43;
                16'd58: res.value = 6'd44;
                default: begin
                    res.bad   = 1'b1;
                    res.value = 6'd1;
                end
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/qr_data_mode_bit_encoder.sv */
// Top level of the QR data segment bit encoder: grouping logic, mode register
// and result register. Depends on qrenc_pkg.
`default_nettype none

// Packs one symbol per request into QR payload bit groups in the mode held by the
// mode register (numeric, alphanumeric, byte or kanji); mode and count headers are
// not produced. A request is taken in every cycle while the result register is
// empty or being drained, and its result, if any, appears in the next cycle; the
// single result register alone sets the rate, so sustained throughput is one
// symbol per cycle while i_ready is high. Numeric and alphanumeric symbols that
// leave a group open without i_last are held and give no result. Writing
// the mode register discards held symbols, and must be done only while idle.
module qr_data_mode_bit_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Symbol requests
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_symbol,
    input  wire logic        i_last,
    // Result requests
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [12:0] o_bits,
    output logic      [3:0]  o_bit_count,
    output logic             o_bad_symbol,
    output logic             o_end_of_segment
);
    import qrenc_pkg::*;

    logic [1:0]  r_mode;
    logic [1:0]  r_pend_count;
    logic [6:0]  r_pend_value;
    logic        r_pend_bad;
    logic [1:0]  n_pend_count;
    logic [6:0]  n_pend_value;
    logic        n_pend_bad;

    logic        r_out_valid;
    logic [12:0] r_bits;
    logic [3:0]  r_bit_count;
    logic        r_bad;
    logic        r_end;
    logic        n_emit;
    logic [12:0] n_bits;
    logic [3:0]  n_bit_count;
    logic        n_bad;

    logic        cfg_write;
    logic        accept;
    t_alnum      alnum;
    logic        dig_ok;
    logic [9:0]  num_value;
    logic [1:0]  num_count;
    logic [10:0] alnum_pair;
    logic [15:0] kanji_off;
    logic        kanji_first;
    logic        kanji_second;
    logic [12:0] kanji_value;

    // Handshakes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODE);
    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;

    // Register read-back.
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_MODE) begin
            prdata = {30'd0, r_mode};
        end
    end

    // Per-mode arithmetic on the incoming symbol.
    always_comb begin
        alnum        = alnum_lookup(i_symbol);
        dig_ok       = (i_symbol >= CHAR_ZERO) && (i_symbol <= CHAR_NINE);
        num_value    = ({3'd0, r_pend_value} << 3) + ({3'd0, r_pend_value} << 1)
                       + {6'd0, (dig_ok ? i_symbol[3:0] : 4'd0)};
        num_count    = r_pend_count + 2'd1;
        alnum_pair   = ({4'd0, r_pend_value} << 5) + ({4'd0, r_pend_value} << 3)
                       + ({4'd0, r_pend_value} << 2) + {4'd0, r_pend_value}
                       + {5'd0, alnum.value};
        kanji_first  = (i_symbol >= KANJI_LO_FIRST) && (i_symbol <= KANJI_HI_FIRST);
        kanji_second = (i_symbol >= KANJI_LO_SECOND) && (i_symbol <= KANJI_HI_SECOND);
        kanji_off    = kanji_first ? (i_symbol - KANJI_LO_FIRST)
                                   : (i_symbol - KANJI_OFS_SECOND);
        // High byte times 192 is (x << 7) + (x << 6).
        kanji_value  = ({7'd0, kanji_off[13:8]} << 7) + ({7'd0, kanji_off[13:8]} << 6)
                       + {5'd0, kanji_off[7:0]};
    end

    // Group completion and next pending state.
    always_comb begin
        n_emit       = 1'b0;
        n_bits       = 13'd0;
        n_bit_count  = BC_NONE;
        n_bad        = 1'b0;
        n_pend_count = 2'd0;
        n_pend_value = 7'd0;
        n_pend_bad   = 1'b0;
        case (r_mode)
            MODE_NUMERIC: begin
                n_bits = {3'd0, num_value};
                n_bad  = r_pend_bad || !dig_ok;
                if (num_count == 2'd3 || i_last) begin
                    n_emit = 1'b1;
                    case (num_count)
                        2'd3:    n_bit_count = BC_NUM_THREE;
                        2'd2:    n_bit_count = BC_NUM_TWO;
                        default: n_bit_count = BC_NUM_ONE;
                    endcase
                end else begin
                    n_pend_count = num_count;
                    n_pend_value = num_value[6:0];
                    n_pend_bad   = n_bad;
                end
            end
            MODE_ALNUM: begin
                if (r_pend_count != 2'd0) begin
                    n_emit      = 1'b1;
                    n_bits      = {2'd0, alnum_pair};
                    n_bit_count = BC_ALNUM_TWO;
                    n_bad       = r_pend_bad || alnum.bad;
                end else if (i_last) begin
                    n_emit      = 1'b1;
                    n_bits      = {7'd0, alnum.value};
                    n_bit_count = BC_ALNUM_ONE;
                    n_bad       = alnum.bad;
                end else begin
                    n_pend_count = 2'd1;
                    n_pend_value = {1'b0, alnum.value};
                    n_pend_bad   = alnum.bad;
                end
            end
            MODE_BYTE: begin
                n_emit      = 1'b1;
                n_bits      = {5'd0, i_symbol[7:0]};
                n_bit_count = BC_BYTE;
                n_bad       = (i_symbol[15:8] != 8'd0);
            end
            default: begin
                n_emit = 1'b1;
                if (kanji_first || kanji_second) begin
                    n_bits      = kanji_value;
                    n_bit_count = BC_KANJI;
                end else begin
                    n_bad = 1'b1;
                end
            end
        endcase
    end

    // Mode register and held symbols.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NUMERIC;
            r_pend_count <= 2'd0;
            r_pend_value <= 7'd0;
            r_pend_bad   <= 1'b0;
        end else if (cfg_write) begin
            r_mode       <= pwdata[1:0];
            r_pend_count <= 2'd0;
            r_pend_value <= 7'd0;
            r_pend_bad   <= 1'b0;
        end else if (accept) begin
            r_pend_count <= n_pend_count;
            r_pend_value <= n_pend_value;
            r_pend_bad   <= n_pend_bad;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_bits      <= n_bits;
            r_bit_count <= n_bit_count;
            r_bad       <= n_bad;
            r_end       <= i_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bits           = r_bits;
    assign o_bit_count      = r_bit_count;
    assign o_bad_symbol     = r_bad;
    assign o_end_of_segment = r_end;

`ifndef SYNTHESIS
    // A byte symbol always produces an 8-bit result in the next cycle.
    a_byte_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cfg_write && r_mode == MODE_BYTE)
        |=> (o_valid && o_bit_count == BC_BYTE))
        else $error("byte symbol did not produce an 8-bit result");

    // A zero-bit result is only a dropped kanji code.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bit_count == BC_NONE) |-> (o_bits == 13'd0 && o_bad_symbol))
        else $error("zero-bit result without flag or with nonzero bits");

    // Alphanumeric mode holds at most one symbol.
    a_alnum_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ALNUM) |-> (r_pend_count <= 2'd1))
        else $error("alphanumeric mode holds more than one symbol");

    // Numeric mode never holds a full group.
    a_num_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NUMERIC) |-> (r_pend_count <= 2'd2 && r_pend_value <= 7'd99))
        else $error("numeric pending state out of range");

    // A full kanji group is never flagged.
    a_kanji_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bit_count == BC_KANJI) |-> !o_bad_symbol)
        else $error("13-bit kanji result carries a bad flag");
`endif

endmodule

`default_nettype wire
